FILE: hdl/amsu_pkg.sv
// Shared constants, payload types and control structs of the ARX model step unit.
`default_nettype none

package amsu_pkg;

  // Model dimensions
  localparam int MAX_NA     = 8;
  localparam int MAX_NB     = 8;
  localparam int MAX_DELAY  = 7;
  localparam int HIST_DEPTH = MAX_NA + MAX_DELAY;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int CMD_W      = 2;
  localparam int CNT_CFG_W  = 4;
  localparam int DLY_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Coefficient store: a taps from slot 0, b taps from slot B_BASE, modulo COEF_SLOTS
  localparam int COEF_SLOTS = 16;
  localparam int COEF_AW    = 4;
  localparam int B_BASE     = 8;

  // Tap memory: two rings of 2**RING_W entries, input samples and output history
  localparam int RING_SPAN = (MAX_NB > HIST_DEPTH) ? MAX_NB : HIST_DEPTH;
  localparam int RING_W    = (RING_SPAN > 1) ? $clog2(RING_SPAN) : 1;
  localparam int TAP_AW    = RING_W + 1;
  localparam int TAP_DEPTH = 2 ** TAP_AW;

  // Tap counter of the sequencer
  localparam int MAX_TAPS  = (MAX_NA > MAX_NB) ? MAX_NA : MAX_NB;
  localparam int TAP_CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  // Arithmetic: Q2.14 x Q1.15 gives Q3.29, rounded back to Q1.15
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(MAX_NA + MAX_NB) + 1;
  localparam int FRAC_SHIFT = 14;
  localparam int RES_W      = ACC_W - FRAC_SHIFT;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);

  // Commands
  localparam logic [CMD_W-1:0] CMD_RUN_OWN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN_MEAS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NB    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [SAMPLE_W-1:0] measured_out;
    logic [COEF_AW-1:0]         coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } amsu_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] model_out;
    logic                       clipped;
  } amsu_out_t;

  // One multiply-accumulate term as issued with its memory reads
  typedef struct packed {
    logic en;
    logic sub;
  } amsu_term_t;

  // Tap memory control from the sequencer
  typedef struct packed {
    logic                       push_in;
    logic                       push_hist;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] past;
    logic                       rd_hist;
    logic [RING_W-1:0]          rd_off;
  } amsu_tap_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/amsu_coef_store.sv
// Coefficient memory with per-slot valid bits so unwritten slots read as zero.
`default_nettype none

module amsu_coef_store
  import amsu_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_en_i,
  input  wire logic [COEF_AW-1:0]       wr_addr_i,
  input  wire logic signed [COEF_W-1:0] wr_data_i,
  input  wire logic [COEF_AW-1:0]       rd_addr_i,
  output logic signed [COEF_W-1:0]      rd_data_o
);

  logic signed [COEF_W-1:0] mem [COEF_SLOTS];
  logic [COEF_SLOTS-1:0]    vld_q;
  logic signed [COEF_W-1:0] rdata_q;
  logic                     rvld_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr_i];
  end

  // Track written slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rvld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

FILE: hdl/amsu_tap_store.sv
// Tap memory holding the input sample ring and the output history ring.
`default_nettype none

module amsu_tap_store
  import amsu_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire amsu_tap_ctl_t        ctl_i,
  output logic signed [SAMPLE_W-1:0] rd_data_o
);

  logic signed [SAMPLE_W-1:0] mem [TAP_DEPTH];
  logic [TAP_DEPTH-1:0]       vld_q;
  logic [RING_W-1:0]          in_ptr_q, in_ptr_d;
  logic [RING_W-1:0]          hist_ptr_q, hist_ptr_d;
  logic                       wr_en;
  logic [TAP_AW-1:0]          wr_addr;
  logic signed [SAMPLE_W-1:0] wr_data;
  logic [TAP_AW-1:0]          rd_addr;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rvld_q;

  // Advance the ring heads; a push writes the slot the head moves to
  always_comb begin
    in_ptr_d   = ctl_i.push_in   ? in_ptr_q + 1'b1   : in_ptr_q;
    hist_ptr_d = ctl_i.push_hist ? hist_ptr_q + 1'b1 : hist_ptr_q;
    wr_en      = ctl_i.push_in | ctl_i.push_hist;
    if (ctl_i.push_hist) begin
      wr_addr = {1'b1, hist_ptr_d};
      wr_data = ctl_i.past;
    end else begin
      wr_addr = {1'b0, in_ptr_d};
      wr_data = ctl_i.sample;
    end
  end

  // Read the entry a given number of places behind the newest one
  assign rd_addr = ctl_i.rd_hist ? {1'b1, hist_ptr_q - ctl_i.rd_off}
                                 : {1'b0, in_ptr_q - ctl_i.rd_off};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  // Ring heads and per-entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ptr_q   <= '0;
      hist_ptr_q <= '0;
      vld_q      <= '0;
      rvld_q     <= 1'b0;
    end else begin
      in_ptr_q   <= in_ptr_d;
      hist_ptr_q <= hist_ptr_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rvld_q <= vld_q[rd_addr];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

  // The single write port takes one push per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.push_in && ctl_i.push_hist))
    else $error("tap store: input and history push in the same cycle");

endmodule

`default_nettype wire

FILE: hdl/amsu_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the sum.
`default_nettype none

module amsu_mac
  import amsu_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clr_i,
  input  wire amsu_term_t                 issue_i,
  input  wire logic signed [COEF_W-1:0]   coef_i,
  input  wire logic signed [SAMPLE_W-1:0] tap_i,
  output logic                            busy_o,
  output amsu_out_t                       res_o
);

  amsu_term_t               term_q;
  logic                     prod_en_q;
  logic                     prod_sub_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  biased;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [RES_W-1:0]  rnd;
  logic                     clip;

  // Clear, accumulate or subtract the registered product
  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (prod_en_q) begin
      if (prod_sub_q) begin
        acc_d = acc_q - ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Product register, aligned with the memory read data
  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * tap_i;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q     <= '0;
      prod_en_q  <= 1'b0;
      prod_sub_q <= 1'b0;
    end else begin
      term_q     <= issue_i;
      prod_en_q  <= term_q.en;
      prod_sub_q <= term_q.sub;
    end
  end

  assign busy_o = term_q.en | prod_en_q;

  // Round half up to Q1.15, then saturate
  always_comb begin
    biased  = acc_q + $signed(ROUND_BIAS);
    shifted = biased >>> FRAC_SHIFT;
    rnd     = shifted[RES_W-1:0];
    clip    = (rnd[RES_W-1:SAMPLE_W-1] != '0) && (rnd[RES_W-1:SAMPLE_W-1] != '1);
    res_o.clipped = clip;
    if (!clip) begin
      res_o.model_out = rnd[SAMPLE_W-1:0];
    end else if (rnd[RES_W-1]) begin
      res_o.model_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res_o.model_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/arx_model_step_unit.sv
// Top level of the ARX model step unit: sequencer, configuration and result register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------------
//   in      | sink      | in_valid_i / in_ready_o  | in_i  (cmd, samples, coefficient)
//   out     | source    | out_valid_o / out_ready_i| out_o (model_out, clipped)
//   cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A run item occupies the unit for nb b terms and then na a terms, one tap term per cycle
// through the single read port of the tap memory and the shared multiplier, then the drain
// of the product and accumulator registers and the rounding into the result register.
// Load and unused commands are taken in the idle state. Reset clears all state at once
// through valid bits; no clearing pass. A stalled result holds the unit in its final cycle
// only when a new result is ready and the previous one has not yet been taken.
`default_nettype none

module arx_model_step_unit
  import amsu_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire amsu_in_t              in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output amsu_out_t                  out_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BTAP   = 5'b00010,
    S_ATAP   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } amsu_state_e;

  amsu_state_e                state_q, state_d;
  logic [TAP_CNT_W-1:0]       term_q, term_d;
  logic                       drain_q, drain_d;
  logic [CNT_CFG_W-1:0]       cfg_na_q, cfg_nb_q;
  logic [DLY_W-1:0]           cfg_dly_q;
  logic signed [SAMPLE_W-1:0] past_q;
  logic signed [SAMPLE_W-1:0] last_result_q;
  amsu_out_t                  out_q;
  logic                       out_valid_q;

  logic                       in_xfer;
  logic                       is_run;
  logic                       is_load;
  logic                       acc_clr;
  logic                       load_out;
  logic [CNT_CFG_W:0]         na_clamp, nb_clamp;
  logic [DLY_W:0]             dly_clamp;
  logic [TAP_CNT_W-1:0]       na_last, nb_last;
  amsu_term_t                 issue;
  amsu_tap_ctl_t              tap_ctl;
  logic [COEF_AW-1:0]         coef_rd_addr;
  logic signed [COEF_W-1:0]   coef_rd;
  logic signed [SAMPLE_W-1:0] tap_rd;
  logic                       mac_busy;
  amsu_out_t                  mac_res;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i & in_ready_o;
  assign is_run      = (in_i.cmd == CMD_RUN_OWN) || (in_i.cmd == CMD_RUN_MEAS);
  assign is_load     = (in_i.cmd == CMD_LOAD);

  // Clamp tap counts and delay to their legal ranges
  always_comb begin
    if (cfg_na_q == '0) begin
      na_clamp = (CNT_CFG_W+1)'(1);
    end else if ({1'b0, cfg_na_q} > (CNT_CFG_W+1)'(MAX_NA)) begin
      na_clamp = (CNT_CFG_W+1)'(MAX_NA);
    end else begin
      na_clamp = {1'b0, cfg_na_q};
    end
    if (cfg_nb_q == '0) begin
      nb_clamp = (CNT_CFG_W+1)'(1);
    end else if ({1'b0, cfg_nb_q} > (CNT_CFG_W+1)'(MAX_NB)) begin
      nb_clamp = (CNT_CFG_W+1)'(MAX_NB);
    end else begin
      nb_clamp = {1'b0, cfg_nb_q};
    end
    if ({1'b0, cfg_dly_q} > (DLY_W+1)'(MAX_DELAY)) begin
      dly_clamp = (DLY_W+1)'(MAX_DELAY);
    end else begin
      dly_clamp = {1'b0, cfg_dly_q};
    end
    na_last = TAP_CNT_W'(na_clamp - 1'b1);
    nb_last = TAP_CNT_W'(nb_clamp - 1'b1);
  end

  // Sequencer: b terms over the input ring, then a terms over the delayed history
  always_comb begin
    state_d           = state_q;
    term_d            = term_q;
    drain_d           = drain_q;
    issue             = '0;
    acc_clr           = 1'b0;
    load_out          = 1'b0;
    coef_rd_addr      = '0;
    tap_ctl           = '0;
    tap_ctl.push_in   = in_xfer & is_run;
    tap_ctl.sample    = in_i.sample_in;
    tap_ctl.past      = past_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && is_run) begin
          state_d = S_BTAP;
          term_d  = '0;
          acc_clr = 1'b1;
        end
      end
      S_BTAP: begin
        issue.en          = 1'b1;
        tap_ctl.push_hist = (term_q == '0);
        tap_ctl.rd_off    = RING_W'(term_q);
        coef_rd_addr      = COEF_AW'(B_BASE) + COEF_AW'(term_q);
        if (term_q == nb_last) begin
          state_d = S_ATAP;
          term_d  = '0;
        end else begin
          term_d = term_q + 1'b1;
        end
      end
      S_ATAP: begin
        // Delay plus tap index never passes the history depth
        issue.en        = 1'b1;
        issue.sub       = 1'b1;
        tap_ctl.rd_hist = 1'b1;
        tap_ctl.rd_off  = RING_W'(dly_clamp) + RING_W'(term_q);
        coef_rd_addr    = COEF_AW'(term_q);
        if (term_q == na_last) begin
          state_d = S_DRAIN;
          drain_d = 1'b0;
        end else begin
          term_d = term_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain_q) begin
          state_d = S_FINISH;
        end else begin
          drain_d = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      term_q        <= '0;
      drain_q       <= 1'b0;
      cfg_na_q      <= CNT_CFG_W'(1);
      cfg_nb_q      <= CNT_CFG_W'(1);
      cfg_dly_q     <= '0;
      last_result_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      drain_q <= drain_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_NA:    cfg_na_q  <= cfg_data_i[CNT_CFG_W-1:0];
          REG_NB:    cfg_nb_q  <= cfg_data_i[CNT_CFG_W-1:0];
          REG_DELAY: cfg_dly_q <= cfg_data_i[DLY_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        last_result_q <= mac_res.model_out;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: past output for the history and the result
  always_ff @(posedge clk_i) begin
    if (in_xfer && is_run) begin
      past_q <= (in_i.cmd == CMD_RUN_MEAS) ? in_i.measured_out : last_result_q;
    end
    if (load_out) begin
      out_q <= mac_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  amsu_coef_store u_coef_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_xfer & is_load),
    .wr_addr_i (in_i.coef_index),
    .wr_data_i (in_i.coef_value),
    .rd_addr_i (coef_rd_addr),
    .rd_data_o (coef_rd)
  );

  amsu_tap_store u_tap_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tap_ctl),
    .rd_data_o (tap_rd)
  );

  amsu_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (acc_clr),
    .issue_i (issue),
    .coef_i  (coef_rd),
    .tap_i   (tap_rd),
    .busy_o  (mac_busy),
    .res_o   (mac_res)
  );

  // A run transfer starts the b-tap pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_run) |=> (state_q == S_BTAP))
    else $error("run transfer did not start the tap pass");

  // The pipeline is empty by the time the sum is rounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |-> !mac_busy)
    else $error("result taken before accumulation finished");

  // A loaded result is shown and recorded as the last output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_o && (last_result_q == out_o.model_out)))
    else $error("result register and last output disagree");

endmodule

`default_nettype wire
